### sv/indexed_list_engine_assert.svh
// assertion macros for the indexed list engine
// included by modules that check their own sequencing; no other dependencies
`ifndef INDEXED_LIST_ENGINE_ASSERT_SVH
`define INDEXED_LIST_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, off during reset
`define ILE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("indexed list engine: assertion failed");
// next-cycle implication, off during reset
`define ILE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("indexed list engine: assertion failed");
`else
`define ILE_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ILE_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### sv/ile_pkg.sv
// shared types and constants of the indexed list engine
// no dependencies; used by ile_step, indexed_list_engine and the testbench
`default_nettype none

package ile_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int ELEM_WIDTH_DEF = 32;
  localparam int POS_WIDTH      = 5;

  typedef enum logic [3:0] {
    F_APPEND   = 4'd0,
    F_INSERT   = 4'd1,
    F_GET      = 4'd2,
    F_SET      = 4'd3,
    F_REMOVE   = 4'd4,
    F_FIND     = 4'd5,
    F_CONTAINS = 4'd6,
    F_CLEAR    = 4'd7,
    F_LENGTH   = 4'd8
  } ile_func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } ile_status_t;

  typedef struct packed {
    logic [3:0]           func;
    logic [POS_WIDTH-1:0] position;
    logic [31:0]          element;
  } ile_in_t;

  typedef struct packed {
    ile_status_t status;
    logic [31:0] element_out;
    logic        found;
    logic [3:0]  found_index;
    logic [4:0]  length;
    logic        empty_res;
  } ile_out_t;

  // flags from the index and compare unit to the sequencer
  typedef struct packed {
    logic more;
    logic match;
  } ile_step_t;

endpackage

`default_nettype wire

### sv/ile_ram.sv
// generic single-write, single-read memory with registered read data
// no dependencies
`default_nettype none

module ile_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### sv/ile_step.sv
// shared index step and element compare unit of the indexed list engine
// depends on ile_pkg
`default_nettype none

module ile_step #(
  parameter int DEPTH      = ile_pkg::DEPTH_DEF,
  parameter int ELEM_WIDTH = ile_pkg::ELEM_WIDTH_DEF
) (
  input  wire logic [$clog2(DEPTH)-1:0]   idx,
  input  wire logic [$clog2(DEPTH+1)-1:0] cnt,
  input  wire logic [$clog2(DEPTH)-1:0]   pos,
  input  wire logic                       down,
  input  wire logic [ELEM_WIDTH-1:0]      rdata,
  input  wire logic [ELEM_WIDTH-1:0]      key,
  output logic      [$clog2(DEPTH)-1:0]   idx_nxt,
  output ile_pkg::ile_step_t              flags
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0] idx_up;

  assign idx_up = CW'(idx) + CW'(1);

  always_comb begin
    if (down) begin
      idx_nxt    = idx - AW'(1);
      flags.more = idx > pos;
    end else begin
      idx_nxt    = idx + AW'(1);
      flags.more = idx_up < cnt;
    end
    flags.match = rdata == key;
  end

endmodule

`default_nettype wire

### sv/indexed_list_engine.sv
// indexed list engine top level: sequencer, entry memory and step unit
// depends on ile_pkg, ile_ram, ile_step and indexed_list_engine_assert.svh
//
// An ordered list of up to DEPTH words kept in a single-port-write memory.
// A request beat is taken when start is high and busy is low; in_data holds
// func, position and element. Exactly one result beat follows per request:
// out_valid is high for one cycle with out_data, and the receiver cannot
// stall it. For get, insert, remove and non-empty searches that pass their
// checks, busy stays high from the cycle after acceptance until the result
// strobe; other requests leave it low. One request is in flight at a time.
// Append, set, clear, length and error cases answer from idle; get reads
// in S_GET; find and contains scan up from index 0 in S_FIND to a match or
// the end. Insert at p moves the tail up via S_SHIFT_RD and S_SHIFT_WR,
// then writes the new word at p; remove at p reads its word in S_RM_HEAD
// and moves the words above p down. Each moved word costs a memory read
// and a write, one port of each, and the search reads one word per cycle
// through the shared compare unit. A synchronous reset empties the list at
// once; the memory is left as is and never read before being written.
`default_nettype none

module indexed_list_engine #(
  parameter int DEPTH      = ile_pkg::DEPTH_DEF,
  parameter int ELEM_WIDTH = ile_pkg::ELEM_WIDTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire ile_pkg::ile_in_t in_data,
  output logic                  out_valid,
  output ile_pkg::ile_out_t     out_data
);

`include "indexed_list_engine_assert.svh"

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > ile_pkg::POS_WIDTH) ? CW : ile_pkg::POS_WIDTH;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GET,
    S_RM_HEAD,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_FIND
  } state_t;

  state_t              state_r;
  logic [CW-1:0]       count_r;
  logic [AW-1:0]       idx_r;
  logic [AW-1:0]       pos_r;
  logic [ELEM_WIDTH-1:0] key_r;
  ile_pkg::ile_func_t  op_r;
  ile_pkg::ile_status_t status_r;
  logic [31:0]         elem_out_r;
  logic                found_r;
  logic [3:0]          fidx_r;
  logic                out_valid_r;

  logic                  accept;
  ile_pkg::ile_func_t    func_in;
  logic [ELEM_WIDTH-1:0] key_in;
  logic [AW-1:0]         pos_in;
  logic [PW-1:0]         pos_w;
  logic [PW-1:0]         cnt_w;
  logic                  full;
  logic                  pos_bad_rd;
  logic                  pos_bad_ins;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [ELEM_WIDTH-1:0] ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [ELEM_WIDTH-1:0] ram_rdata;

  logic [AW-1:0]         idx_nxt;
  ile_pkg::ile_step_t    step;

  assign busy        = state_r != S_IDLE;
  assign accept      = start && !busy;
  assign func_in     = ile_pkg::ile_func_t'(in_data.func);
  assign key_in      = ELEM_WIDTH'(in_data.element);
  assign pos_in      = AW'(in_data.position);
  assign pos_w       = PW'(in_data.position);
  assign cnt_w       = PW'(count_r);
  assign full        = count_r == CW'(DEPTH);
  assign pos_bad_rd  = pos_w >= cnt_w;
  assign pos_bad_ins = pos_w > cnt_w;

  ile_ram #(
    .WIDTH (ELEM_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ile_step #(
    .DEPTH      (DEPTH),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_step (
    .idx     (idx_r),
    .cnt     (count_r),
    .pos     (pos_r),
    .down    (op_r == ile_pkg::F_INSERT),
    .rdata   (ram_rdata),
    .key     (key_r),
    .idx_nxt (idx_nxt),
    .flags   (step)
  );

  // memory port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = ram_rdata;
    ram_raddr = idx_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (func_in)
            ile_pkg::F_APPEND: begin
              ram_we    = !full;
              ram_waddr = count_r[AW-1:0];
              ram_wdata = key_in;
            end
            ile_pkg::F_SET: begin
              ram_we    = !pos_bad_rd;
              ram_waddr = pos_in;
              ram_wdata = key_in;
            end
            ile_pkg::F_GET, ile_pkg::F_REMOVE: ram_raddr = pos_in;
            ile_pkg::F_FIND, ile_pkg::F_CONTAINS: ram_raddr = '0;
            default: ;
          endcase
        end
      end
      S_SHIFT_RD: begin
        if (step.more) begin
          ram_raddr = idx_nxt;
        end else if (op_r == ile_pkg::F_INSERT) begin
          // shifting done, drop the new word into the gap
          ram_we    = 1'b1;
          ram_waddr = pos_r;
          ram_wdata = key_r;
        end
      end
      S_SHIFT_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r;
        ram_wdata = ram_rdata;
        ram_raddr = idx_nxt;
      end
      S_FIND: ram_raddr = idx_nxt;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            op_r       <= func_in;
            key_r      <= key_in;
            pos_r      <= pos_in;
            status_r   <= ile_pkg::ST_OK;
            elem_out_r <= '0;
            found_r    <= 1'b0;
            fidx_r     <= '0;
            unique case (func_in)
              ile_pkg::F_APPEND: begin
                if (full) begin
                  status_r <= ile_pkg::ST_FULL;
                end else begin
                  count_r <= count_r + CW'(1);
                end
                out_valid_r <= 1'b1;
              end
              ile_pkg::F_INSERT: begin
                // range check ahead of the full check
                if (pos_bad_ins) begin
                  status_r    <= ile_pkg::ST_RANGE;
                  out_valid_r <= 1'b1;
                end else if (full) begin
                  status_r    <= ile_pkg::ST_FULL;
                  out_valid_r <= 1'b1;
                end else begin
                  idx_r   <= count_r[AW-1:0];
                  state_r <= S_SHIFT_RD;
                end
              end
              ile_pkg::F_GET: begin
                if (pos_bad_rd) begin
                  status_r    <= ile_pkg::ST_RANGE;
                  out_valid_r <= 1'b1;
                end else begin
                  state_r <= S_GET;
                end
              end
              ile_pkg::F_SET: begin
                if (pos_bad_rd) begin
                  status_r <= ile_pkg::ST_RANGE;
                end
                out_valid_r <= 1'b1;
              end
              ile_pkg::F_REMOVE: begin
                if (pos_bad_rd) begin
                  status_r    <= ile_pkg::ST_RANGE;
                  out_valid_r <= 1'b1;
                end else begin
                  idx_r   <= pos_in;
                  state_r <= S_RM_HEAD;
                end
              end
              ile_pkg::F_FIND, ile_pkg::F_CONTAINS: begin
                if (count_r == '0) begin
                  out_valid_r <= 1'b1;
                end else begin
                  idx_r   <= '0;
                  state_r <= S_FIND;
                end
              end
              ile_pkg::F_CLEAR: begin
                count_r     <= '0;
                out_valid_r <= 1'b1;
              end
              ile_pkg::F_LENGTH: out_valid_r <= 1'b1;
              default: out_valid_r <= 1'b1;
            endcase
          end
        end
        S_GET: begin
          elem_out_r  <= 32'(ram_rdata);
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        S_RM_HEAD: begin
          elem_out_r <= 32'(ram_rdata);
          state_r    <= S_SHIFT_RD;
        end
        S_SHIFT_RD: begin
          if (step.more) begin
            state_r <= S_SHIFT_WR;
          end else begin
            if (op_r == ile_pkg::F_INSERT) begin
              count_r <= count_r + CW'(1);
            end else begin
              count_r <= count_r - CW'(1);
            end
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        S_SHIFT_WR: begin
          idx_r   <= idx_nxt;
          state_r <= S_SHIFT_RD;
        end
        S_FIND: begin
          if (step.match) begin
            found_r     <= 1'b1;
            fidx_r      <= 4'(idx_r);
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end else if (!step.more) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end else begin
            idx_r <= idx_nxt;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;

  // count is stable from the finishing edge until the next beat is taken
  always_comb begin
    out_data.status      = status_r;
    out_data.element_out = elem_out_r;
    out_data.found       = found_r;
    out_data.found_index = fidx_r;
    out_data.length      = 5'(count_r);
    out_data.empty_res   = count_r == '0;
  end

  `ILE_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_r <= CW'(DEPTH))
  `ILE_ASSERT_IMP(a_strobe_idle, clk, rst_n, out_valid_r, state_r == S_IDLE)
  `ILE_ASSERT_NXT(a_accept_progress, clk, rst_n, accept, out_valid_r || busy)
  `ILE_ASSERT_IMP(a_find_in_list, clk, rst_n, state_r == S_FIND, CW'(idx_r) < count_r)

endmodule

`default_nettype wire

### tb/tb_indexed_list_engine.sv
// self-checking testbench for the indexed list engine: directed and random request beats
// depends on ile_pkg and indexed_list_engine; predicts every result beat with its own list model
`timescale 1ns / 100ps
`default_nettype none

module tb_indexed_list_engine;
  import ile_pkg::*;

  localparam int LIST_DEPTH     = DEPTH_DEF;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 40;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     start;
  logic     busy;
  ile_in_t  in_data;
  logic     out_valid;
  ile_out_t out_data;

  // shadow copy of the list, updated at each accepted request beat
  logic [31:0] shadow_words [LIST_DEPTH];
  int          shadow_len;

  ile_out_t pending_results [$];
  int       fail_count;
  int       requests_sent;
  int       results_seen;
  int       full_hits;
  int       range_hits;
  int       search_hits;
  int       idle_cycles;
  logic     burst_no_gaps;

  indexed_list_engine u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic ile_in_t build_request(logic [3:0] f, int p, logic [31:0] e);
    ile_in_t req;
    req.func     = f;
    req.position = 5'(p);
    req.element  = e;
    return req;
  endfunction

  // expected result of one request, applied to the shadow list
  function automatic ile_out_t apply_request(ile_in_t req);
    ile_out_t r;
    int       p;
    int       i;
    r = '0;
    p = int'(req.position);
    case (req.func)
      F_APPEND: begin
        if (shadow_len >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          shadow_words[shadow_len] = req.element;
          shadow_len++;
        end
      end
      F_INSERT: begin
        // range check takes priority over the full check
        if (p > shadow_len) begin
          r.status = ST_RANGE;
        end else if (shadow_len >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (i = shadow_len; i > p; i--) shadow_words[i] = shadow_words[i-1];
          shadow_words[p] = req.element;
          shadow_len++;
        end
      end
      F_GET: begin
        if (p >= shadow_len) r.status = ST_RANGE;
        else r.element_out = shadow_words[p];
      end
      F_SET: begin
        if (p >= shadow_len) r.status = ST_RANGE;
        else shadow_words[p] = req.element;
      end
      F_REMOVE: begin
        if (p >= shadow_len) begin
          r.status = ST_RANGE;
        end else begin
          r.element_out = shadow_words[p];
          for (i = p; i + 1 < shadow_len; i++) shadow_words[i] = shadow_words[i+1];
          shadow_len--;
        end
      end
      F_FIND, F_CONTAINS: begin
        for (i = 0; i < shadow_len; i++) begin
          if (!r.found && shadow_words[i] == req.element) begin
            r.found       = 1'b1;
            r.found_index = i[3:0];
          end
        end
      end
      F_CLEAR: shadow_len = 0;
      default: ;
    endcase
    r.length    = 5'(shadow_len);
    r.empty_res = (shadow_len == 0);
    return r;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (burst_no_gaps || roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // small set of words so that searches see duplicates
  function automatic logic [31:0] pool_word();
    case ($urandom_range(0, 5))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h0000_0001;
      4: return 32'hA5A5_A5A5;
      default: return 32'h5A5A_5A5A;
    endcase
  endfunction

  task automatic send_request(ile_in_t req);
    int       gap;
    ile_out_t want;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data <= req;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    want = apply_request(req);
    pending_results.push_back(want);
    requests_sent++;
    if (want.status == ST_FULL) full_hits++;
    if (want.status == ST_RANGE) range_hits++;
    if (want.found) search_hits++;
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    fail_count++;
  endtask

  task automatic test_edge_cases();
    send_request(build_request(F_LENGTH, 0, 32'h0));
    send_request(build_request(F_GET, 0, 32'h0));
    send_request(build_request(F_REMOVE, 0, 32'h0));
    send_request(build_request(F_INSERT, 1, 32'h1111_1111));
    send_request(build_request(F_SET, 0, 32'h2222_2222));
    send_request(build_request(F_APPEND, 16, 32'hFFFF_FFFF));
    send_request(build_request(F_INSERT, 0, 32'h0000_0000));
    send_request(build_request(F_INSERT, 2, 32'h8000_0000));
    send_request(build_request(F_FIND, 0, 32'h8000_0000));
    send_request(build_request(F_CONTAINS, 0, 32'hFFFF_FFFF));
    send_request(build_request(F_FIND, 0, 32'h1234_5678));
    send_request(build_request(F_SET, 1, 32'h7FFF_FFFF));
    send_request(build_request(F_SET, 3, 32'h3333_3333));
    send_request(build_request(F_GET, 1, 32'h0));
    send_request(build_request(F_REMOVE, 0, 32'h0));
    send_request(build_request(4'd9, 7, 32'hDEAD_BEEF));
    send_request(build_request(4'd15, 16, 32'hFFFF_FFFF));
    send_request(build_request(F_CLEAR, 0, 32'h0));
    send_request(build_request(F_GET, 0, 32'h0));
  endtask

  task automatic test_full_list();
    for (int k = 0; k < LIST_DEPTH; k++)
      send_request(build_request(F_APPEND, 0, pool_word()));
    send_request(build_request(F_APPEND, 0, 32'hCAFE_F00D));
    send_request(build_request(F_INSERT, 16, 32'hCAFE_F00D));
    send_request(build_request(F_INSERT, 4, 32'hCAFE_F00D));
    send_request(build_request(F_GET, 15, 32'h0));
    send_request(build_request(F_GET, 16, 32'h0));
    send_request(build_request(F_CONTAINS, 0, shadow_words[LIST_DEPTH-1]));
    send_request(build_request(F_REMOVE, 15, 32'h0));
    send_request(build_request(F_INSERT, 0, 32'hFFFF_FFFF));
    send_request(build_request(F_REMOVE, 0, 32'h0));
  endtask

  function automatic ile_in_t random_request(int grow_pct, int shrink_pct);
    ile_in_t req;
    int      roll;
    int      p;
    roll = $urandom_range(0, 99);
    req.element = ($urandom_range(0, 9) < 4) ? pool_word() : 32'($urandom);
    if (roll < grow_pct) begin
      req.func = $urandom_range(0, 1) ? F_INSERT : F_APPEND;
    end else if (roll < grow_pct + shrink_pct) begin
      req.func = F_REMOVE;
    end else if (roll == 99) begin
      req.func = 4'($urandom_range(9, 15));
    end else if (roll == 98) begin
      req.func = F_CLEAR;
    end else begin
      case ($urandom_range(0, 4))
        0: req.func = F_GET;
        1: req.func = F_SET;
        2: req.func = F_FIND;
        3: req.func = F_CONTAINS;
        default: req.func = F_LENGTH;
      endcase
    end
    // mostly in-range positions, some anywhere from 0 to 16
    if ($urandom_range(0, 99) < 85) begin
      if (req.func == F_INSERT) p = $urandom_range(0, shadow_len);
      else p = (shadow_len > 0) ? $urandom_range(0, shadow_len - 1) : 0;
    end else begin
      p = $urandom_range(0, 16);
    end
    req.position = 5'(p);
    if ((req.func == F_FIND || req.func == F_CONTAINS) && shadow_len > 0 &&
        $urandom_range(0, 9) < 6)
      req.element = shadow_words[$urandom_range(0, shadow_len - 1)];
    return req;
  endfunction

  task automatic random_traffic(int n_items, int grow_pct, int shrink_pct);
    for (int k = 0; k < n_items; k++) begin
      if (k % 50 == 0) burst_no_gaps = ($urandom_range(0, 3) == 0);
      send_request(random_request(grow_pct, shrink_pct));
    end
    burst_no_gaps = 1'b0;
  endtask

  // result beats are checked against the oldest prediction
  always @(posedge clk) begin
    ile_out_t want;
    if (rst_n && out_valid) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with no request outstanding");
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d",
                                    out_data.status, want.status));
        if (out_data.element_out !== want.element_out)
          report_mismatch($sformatf("element_out got %h want %h",
                                    out_data.element_out, want.element_out));
        if (out_data.found !== want.found)
          report_mismatch($sformatf("found got %b want %b", out_data.found, want.found));
        if (out_data.found_index !== want.found_index)
          report_mismatch($sformatf("found_index got %0d want %0d",
                                    out_data.found_index, want.found_index));
        if (out_data.length !== want.length)
          report_mismatch($sformatf("length got %0d want %0d",
                                    out_data.length, want.length));
        if (out_data.empty_res !== want.empty_res)
          report_mismatch($sformatf("empty_res got %b want %b",
                                    out_data.empty_res, want.empty_res));
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    rst_n         = 1'b0;
    start         = 1'b0;
    in_data       = '0;
    shadow_len    = 0;
    fail_count    = 0;
    requests_sent = 0;
    results_seen  = 0;
    full_hits     = 0;
    range_hits    = 0;
    search_hits   = 0;
    idle_cycles   = 0;
    burst_no_gaps = 1'b0;
    for (int k = 0; k < LIST_DEPTH; k++) shadow_words[k] = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_edge_cases();
    test_full_list();
    wait_idle();
    random_traffic(600, 30, 25);
    wait_idle();
    random_traffic(500, 55, 10);
    wait_idle();
    random_traffic(400, 12, 45);
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d requests and %0d result beats over all functions",
             requests_sent, results_seen);
    $display("full status %0d times, range status %0d times, search hits %0d",
             full_hits, range_hits, search_hits);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
